// ===== design/m3i_pkg.sv =====
`timescale 1ns / 1ps

package m3i_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int COF_W = 2 * ELEM_WIDTH + 1;
    localparam int PART_W = 2 * ELEM_WIDTH + 1;
    localparam int TERM_W = 3 * ELEM_WIDTH + 2;
    localparam int DET_W = 3 * ELEM_WIDTH + 3;
    localparam int QUO_W = ELEM_WIDTH + 1;
    localparam int DIV_W = 4 * ELEM_WIDTH + 6;
    localparam int LANE_LAT = QUO_W + 1;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0] cof_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [DET_W-1:0] det_t;
    typedef logic [DIV_W-1:0] div_word_t;
    typedef logic [QUO_W-1:0] quo_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } matrix_req_t;

    typedef struct packed {
        elem_t b00;
        elem_t b01;
        elem_t b02;
        elem_t b10;
        elem_t b11;
        elem_t b12;
        elem_t b20;
        elem_t b21;
        elem_t b22;
        elem_t det_out;
        logic  singular;
        logic  overflow;
    } inverse_res_t;

    typedef struct packed {
        logic big;
        logic neg;
        quo_t quo;
    } div_res_t;

endpackage

// ===== design/m3i_cofactor.sv =====
`timescale 1ns / 1ps

module m3i_cofactor (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  m3i_pkg::elem_t  in_mat [9],
    output logic            out_valid,
    output m3i_pkg::elem_t  out_mat [9],
    output m3i_pkg::cof_t   out_cof [9]
);

    m3i_pkg::prod_t p1_reg [9];
    m3i_pkg::prod_t p2_reg [9];
    m3i_pkg::prod_t p1_next [9];
    m3i_pkg::prod_t p2_next [9];
    m3i_pkg::cof_t  cof_reg [9];
    m3i_pkg::cof_t  cof_next [9];
    m3i_pkg::elem_t mat_a_reg [9];
    m3i_pkg::elem_t mat_b_reg [9];
    logic           valid_a_reg;
    logic           valid_b_reg;

    genvar k;
    generate
        for (k = 0; k < 9; k++)
        begin : g_cof
            localparam int I = k / 3;
            localparam int J = k % 3;
            localparam int I1 = (I + 1) % 3;
            localparam int I2 = (I + 2) % 3;
            localparam int J1 = (J + 1) % 3;
            localparam int J2 = (J + 2) % 3;

            always_comb
            begin
                p1_next[k] = m3i_pkg::prod_t'(in_mat[I1*3+J1]) * m3i_pkg::prod_t'(in_mat[I2*3+J2]);
                p2_next[k] = m3i_pkg::prod_t'(in_mat[I1*3+J2]) * m3i_pkg::prod_t'(in_mat[I2*3+J1]);
                cof_next[k] = m3i_pkg::cof_t'(p1_reg[k]) - m3i_pkg::cof_t'(p2_reg[k]);
            end

            always_ff @(posedge clk)
            begin
                p1_reg[k] <= p1_next[k];
                p2_reg[k] <= p2_next[k];
                cof_reg[k] <= cof_next[k];
                mat_a_reg[k] <= in_mat[k];
                mat_b_reg[k] <= mat_a_reg[k];
            end

            assign out_cof[k] = cof_reg[k];
            assign out_mat[k] = mat_b_reg[k];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;

endmodule

// ===== design/m3i_det.sv =====
`timescale 1ns / 1ps

module m3i_det (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  m3i_pkg::elem_t  in_mat [9],
    input  m3i_pkg::cof_t   in_cof [9],
    output logic            out_valid,
    output m3i_pkg::elem_t  out_mat [9],
    output m3i_pkg::cof_t   out_cof [9],
    output m3i_pkg::det_t   out_det
);

    localparam int E = m3i_pkg::ELEM_WIDTH;

    m3i_pkg::part_t lo_reg [3];
    m3i_pkg::part_t hi_reg [3];
    m3i_pkg::part_t lo_next [3];
    m3i_pkg::part_t hi_next [3];
    m3i_pkg::term_t term_reg [3];
    m3i_pkg::term_t term_next [3];
    m3i_pkg::det_t  det_reg;
    m3i_pkg::det_t  det_next;
    m3i_pkg::elem_t mat_reg [3][9];
    m3i_pkg::cof_t  cof_reg [3][9];
    logic [2:0]     valid_reg;

    genvar j;
    generate
        for (j = 0; j < 3; j++)
        begin : g_term
            always_comb
            begin
                lo_next[j] = m3i_pkg::part_t'(in_mat[j])
                           * m3i_pkg::part_t'($signed({1'b0, in_cof[j][E-1:0]}));
                hi_next[j] = m3i_pkg::part_t'(in_mat[j])
                           * m3i_pkg::part_t'($signed(in_cof[j][2*E:E]));
                term_next[j] = (m3i_pkg::term_t'(hi_reg[j]) <<< E) + m3i_pkg::term_t'(lo_reg[j]);
            end

            always_ff @(posedge clk)
            begin
                lo_reg[j] <= lo_next[j];
                hi_reg[j] <= hi_next[j];
                term_reg[j] <= term_next[j];
            end
        end
    endgenerate

    always_comb
    begin
        det_next = m3i_pkg::det_t'(term_reg[0]) + m3i_pkg::det_t'(term_reg[1])
                 + m3i_pkg::det_t'(term_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
        mat_reg[0] <= in_mat;
        cof_reg[0] <= in_cof;
        mat_reg[1] <= mat_reg[0];
        cof_reg[1] <= cof_reg[0];
        mat_reg[2] <= mat_reg[1];
        cof_reg[2] <= cof_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[2];
    assign out_mat = mat_reg[2];
    assign out_cof = cof_reg[2];
    assign out_det = det_reg;

endmodule

// ===== design/m3i_div_lane.sv =====
`timescale 1ns / 1ps

module m3i_div_lane (
    input  logic                  clk,
    input  m3i_pkg::div_word_t    num,
    input  m3i_pkg::div_word_t    den,
    input  logic                  neg,
    output m3i_pkg::div_res_t     res
);

    localparam int QW = m3i_pkg::QUO_W;

    m3i_pkg::div_word_t rem_reg [QW+1];
    m3i_pkg::div_word_t den_reg [QW+1];
    m3i_pkg::quo_t      quo_reg [QW+1];
    logic               big_reg [QW+1];
    logic               neg_reg [QW+1];
    m3i_pkg::div_word_t rem_next [QW+1];
    m3i_pkg::quo_t      quo_next [QW+1];
    logic               big_next;

    always_comb
    begin
        big_next = (num >= (den << QW));
        rem_next[0] = num;
        quo_next[0] = '0;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        quo_reg[0] <= quo_next[0];
        den_reg[0] <= den;
        big_reg[0] <= big_next;
        neg_reg[0] <= neg;
    end

    genvar s;
    generate
        for (s = 1; s <= QW; s++)
        begin : g_step
            localparam int B = QW - s;
            m3i_pkg::div_word_t trial;

            always_comb
            begin
                trial = den_reg[s-1] << B;
                rem_next[s] = rem_reg[s-1];
                quo_next[s] = quo_reg[s-1];
                if (rem_reg[s-1] >= trial)
                begin
                    rem_next[s] = rem_reg[s-1] - trial;
                    quo_next[s][B] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_reg[s-1];
                big_reg[s] <= big_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    endgenerate

    assign res.big = big_reg[QW];
    assign res.neg = neg_reg[QW];
    assign res.quo = quo_reg[QW];

endmodule

// ===== design/matrix3_inverse_top.sv =====
`timescale 1ns / 1ps

// Inverts one 3x3 signed fixed-point matrix per request by the adjugate over the
// determinant, with every quotient rounded to nearest and saturated. A request is
// taken in every cycle and its result appears with done at the end of the pipeline,
// one result per cycle; busy stays low. Each result is on the result port only for
// the single cycle in which done is high.
// The receiver cannot hold it off and must take it in that cycle.
// Most of the pipeline is made up of the nine restoring dividers, which resolve one
// quotient bit per pipeline stage.
module matrix3_inverse_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  m3i_pkg::matrix_req_t   request,
    output logic                   done,
    output m3i_pkg::inverse_res_t  result
);

    localparam int E = m3i_pkg::ELEM_WIDTH;
    localparam int LL = m3i_pkg::LANE_LAT;
    localparam int LAT = LL + 8;
    localparam m3i_pkg::det_t HALF = m3i_pkg::det_t'(1) <<< (2 * FRAC_BITS - 1);
    localparam m3i_pkg::elem_t EMAX = {1'b0, {(E-1){1'b1}}};
    localparam m3i_pkg::elem_t EMIN = {1'b1, {(E-1){1'b0}}};

    m3i_pkg::elem_t     in_mat [9];
    logic               cof_valid;
    m3i_pkg::elem_t     cof_mat [9];
    m3i_pkg::cof_t      cof_cof [9];
    logic               det_valid;
    m3i_pkg::elem_t     det_mat [9];
    m3i_pkg::cof_t      det_cof [9];
    m3i_pkg::det_t      det_val;

    logic               prep_valid_reg;
    m3i_pkg::elem_t     prep_mat_reg [9];
    logic               dneg_reg;
    logic               zero_reg;
    logic [m3i_pkg::DET_W-1:0] dmag_reg;
    m3i_pkg::elem_t     dout_reg;
    logic               dovf_reg;
    logic [m3i_pkg::COF_W-1:0] cmag_reg [9];
    logic               cneg_reg [9];
    logic [m3i_pkg::DET_W-1:0] dmag_next;
    m3i_pkg::det_t      rnd;
    m3i_pkg::det_t      rnd_hi;
    m3i_pkg::elem_t     dout_next;
    logic               dovf_next;

    logic               num_valid_reg;
    m3i_pkg::elem_t     num_mat_reg [9];
    logic               num_zero_reg;
    m3i_pkg::elem_t     num_dout_reg;
    logic               num_dovf_reg;
    m3i_pkg::div_word_t num_reg [9];
    m3i_pkg::div_word_t den_reg;
    logic               neg_reg [9];

    logic               dl_valid_reg [LL];
    m3i_pkg::elem_t     dl_mat_reg [LL][9];
    logic               dl_zero_reg [LL];
    m3i_pkg::elem_t     dl_dout_reg [LL];
    logic               dl_dovf_reg [LL];

    m3i_pkg::div_res_t  lane_res [9];
    m3i_pkg::elem_t     b_next [9];
    logic [8:0]         lovf;

    logic               done_reg;
    m3i_pkg::inverse_res_t result_reg;
    m3i_pkg::inverse_res_t result_next;

    assign in_mat[0] = request.a00;
    assign in_mat[1] = request.a01;
    assign in_mat[2] = request.a02;
    assign in_mat[3] = request.a10;
    assign in_mat[4] = request.a11;
    assign in_mat[5] = request.a12;
    assign in_mat[6] = request.a20;
    assign in_mat[7] = request.a21;
    assign in_mat[8] = request.a22;

    m3i_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_mat    (in_mat),
        .out_valid (cof_valid),
        .out_mat   (cof_mat),
        .out_cof   (cof_cof)
    );

    m3i_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .in_mat    (cof_mat),
        .in_cof    (cof_cof),
        .out_valid (det_valid),
        .out_mat   (det_mat),
        .out_cof   (det_cof),
        .out_det   (det_val)
    );

    always_comb
    begin
        dmag_next = det_val[m3i_pkg::DET_W-1] ? (m3i_pkg::DET_W)'(-det_val)
                                              : (m3i_pkg::DET_W)'(det_val);
        rnd = (det_val + HALF) >>> (2 * FRAC_BITS);
        rnd_hi = rnd >>> (E - 1);
        dovf_next = !((rnd_hi == '0) || (rnd_hi == '1));
        if (!dovf_next)
        begin
            dout_next = rnd[E-1:0];
        end
        else
        begin
            dout_next = rnd[m3i_pkg::DET_W-1] ? EMIN : EMAX;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_mat_reg <= det_mat;
        dneg_reg <= det_val[m3i_pkg::DET_W-1];
        zero_reg <= (det_val == '0);
        dmag_reg <= dmag_next;
        dout_reg <= dout_next;
        dovf_reg <= dovf_next;
        num_mat_reg <= prep_mat_reg;
        num_zero_reg <= zero_reg;
        num_dout_reg <= dout_reg;
        num_dovf_reg <= dovf_reg;
        den_reg <= (m3i_pkg::DIV_W)'(dmag_reg) << 1;
    end

    genvar k;
    generate
        for (k = 0; k < 9; k++)
        begin : g_lane
            localparam int I = k / 3;
            localparam int J = k % 3;

            always_ff @(posedge clk)
            begin
                cneg_reg[k] <= det_cof[J*3+I][m3i_pkg::COF_W-1];
                cmag_reg[k] <= det_cof[J*3+I][m3i_pkg::COF_W-1]
                             ? (m3i_pkg::COF_W)'(-det_cof[J*3+I])
                             : (m3i_pkg::COF_W)'(det_cof[J*3+I]);
                num_reg[k] <= ((m3i_pkg::DIV_W)'(cmag_reg[k]) << (2 * FRAC_BITS + 1))
                            + (m3i_pkg::DIV_W)'(dmag_reg);
                neg_reg[k] <= cneg_reg[k] ^ dneg_reg;
            end

            m3i_div_lane u_lane (
                .clk (clk),
                .num (num_reg[k]),
                .den (den_reg),
                .neg (neg_reg[k]),
                .res (lane_res[k])
            );

            always_comb
            begin
                if (lane_res[k].big)
                begin
                    lovf[k] = 1'b1;
                end
                else if (lane_res[k].neg)
                begin
                    lovf[k] = (lane_res[k].quo > m3i_pkg::QUO_W'(EMAX) + 1'b1);
                end
                else
                begin
                    lovf[k] = (lane_res[k].quo[m3i_pkg::QUO_W-1:E-1] != '0);
                end
                if (lovf[k])
                begin
                    b_next[k] = lane_res[k].neg ? EMIN : EMAX;
                end
                else if (lane_res[k].neg)
                begin
                    b_next[k] = -lane_res[k].quo[E-1:0];
                end
                else
                begin
                    b_next[k] = lane_res[k].quo[E-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        dl_mat_reg[0] <= num_mat_reg;
        dl_zero_reg[0] <= num_zero_reg;
        dl_dout_reg[0] <= num_dout_reg;
        dl_dovf_reg[0] <= num_dovf_reg;
        for (int s = 1; s < LL; s++)
        begin
            dl_mat_reg[s] <= dl_mat_reg[s-1];
            dl_zero_reg[s] <= dl_zero_reg[s-1];
            dl_dout_reg[s] <= dl_dout_reg[s-1];
            dl_dovf_reg[s] <= dl_dovf_reg[s-1];
        end
    end

    always_comb
    begin
        if (dl_zero_reg[LL-1])
        begin
            result_next.b00 = dl_mat_reg[LL-1][0];
            result_next.b01 = dl_mat_reg[LL-1][1];
            result_next.b02 = dl_mat_reg[LL-1][2];
            result_next.b10 = dl_mat_reg[LL-1][3];
            result_next.b11 = dl_mat_reg[LL-1][4];
            result_next.b12 = dl_mat_reg[LL-1][5];
            result_next.b20 = dl_mat_reg[LL-1][6];
            result_next.b21 = dl_mat_reg[LL-1][7];
            result_next.b22 = dl_mat_reg[LL-1][8];
            result_next.det_out = '0;
            result_next.singular = 1'b1;
            result_next.overflow = 1'b0;
        end
        else
        begin
            result_next.b00 = b_next[0];
            result_next.b01 = b_next[1];
            result_next.b02 = b_next[2];
            result_next.b10 = b_next[3];
            result_next.b11 = b_next[4];
            result_next.b12 = b_next[5];
            result_next.b20 = b_next[6];
            result_next.b21 = b_next[7];
            result_next.b22 = b_next[8];
            result_next.det_out = dl_dout_reg[LL-1];
            result_next.singular = 1'b0;
            result_next.overflow = (|lovf) || dl_dovf_reg[LL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            num_valid_reg <= 1'b0;
            for (int s = 0; s < LL; s++)
            begin
                dl_valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= det_valid;
            num_valid_reg <= prep_valid_reg;
            dl_valid_reg[0] <= num_valid_reg;
            for (int s = 1; s < LL; s++)
            begin
                dl_valid_reg[s] <= dl_valid_reg[s-1];
            end
            done_reg <= dl_valid_reg[LL-1];
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request did not complete after the pipeline latency");

    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.singular) |-> (!result.overflow && (result.det_out == '0)))
        else $error("singular result carries overflow or a nonzero determinant");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && $past(start)) |-> !busy)
        else $error("pipeline refused back-to-back requests");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import m3i_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        matrix_req_t  m;
        bit           typed;
        inverse_res_t exp;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    matrix_req_t  request = '0;
    logic         done;
    inverse_res_t result;

    inverse_res_t pending_inverses[$];
    inverse_res_t typed_exp;
    bit           use_typed;
    bit           took;
    int           mismatches;
    int           requests_sent;
    int           results_seen;
    int           singular_seen;
    int           overflow_seen;
    stim_row_t    directed[$];

    matrix3_inverse_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic elem_t saturate(wide_t v, inout bit ovf);
        if (v > 256'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -256'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic inverse_res_t invert_matrix(matrix_req_t m);
        elem_t        e[9];
        elem_t        b[9];
        wide_t        a[9];
        wide_t        cf[9];
        wide_t        det;
        wide_t        mag;
        wide_t        cm;
        wide_t        q;
        bit           ovf;
        bit           dneg;
        bit           cneg;
        int           i1, i2, j1, j2;
        inverse_res_t r;
        e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        ovf = 1'b0;
        for (int k = 0; k < 9; k++)
            a[k] = e[k];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                i1 = (i + 1) % 3;
                i2 = (i + 2) % 3;
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                cf[i*3+j] = a[i1*3+j1] * a[i2*3+j2] - a[i1*3+j2] * a[i2*3+j1];
            end
        end
        det = a[0] * cf[0] + a[1] * cf[1] + a[2] * cf[2];
        if (det == 0)
        begin
            b = e;
            r.det_out = '0;
            r.singular = 1'b1;
        end
        else
        begin
            dneg = det < 0;
            mag = dneg ? -det : det;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    cm = cf[j*3+i];
                    cneg = cm < 0;
                    if (cneg)
                        cm = -cm;
                    q = ((cm <<< 33) + mag) / (mag <<< 1);
                    if (cneg != dneg)
                        q = -q;
                    b[i*3+j] = saturate(q, ovf);
                end
            end
            r.det_out = saturate((det + (256'sd1 <<< 31)) >>> 32, ovf);
            r.singular = 1'b0;
        end
        r.b00 = b[0]; r.b01 = b[1]; r.b02 = b[2];
        r.b10 = b[3]; r.b11 = b[4]; r.b12 = b[5];
        r.b20 = b[6]; r.b21 = b[7]; r.b22 = b[8];
        r.overflow = ovf;
        return r;
    endfunction

    function automatic matrix_req_t pack_matrix(elem_t e[9]);
        matrix_req_t m;
        m.a00 = e[0]; m.a01 = e[1]; m.a02 = e[2];
        m.a10 = e[3]; m.a11 = e[4]; m.a12 = e[5];
        m.a20 = e[6]; m.a21 = e[7]; m.a22 = e[8];
        return m;
    endfunction

    function automatic matrix_req_t diag_matrix(elem_t d, elem_t off);
        elem_t e[9];
        for (int k = 0; k < 9; k++)
            e[k] = (k % 4 == 0) ? d : off;
        return pack_matrix(e);
    endfunction

    function automatic inverse_res_t diag_result(elem_t d, elem_t off, elem_t det,
                                                 logic sing, logic ovf);
        inverse_res_t r;
        matrix_req_t  m;
        m = diag_matrix(d, off);
        r = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22,
              det, sing, ovf};
        return r;
    endfunction

    function automatic elem_t small_elem();
        return elem_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    function automatic matrix_req_t random_matrix();
        elem_t e[9];
        int    kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            e[k] = (kind < 3) ? elem_t'($urandom) : small_elem();
        if (kind == 3)
        begin
            for (int k = 0; k < 3; k++)
                e[6+k] = e[k];
        end
        else if (kind == 4)
        begin
            for (int k = 0; k < 3; k++)
                e[k*3+2] = 0;
        end
        else if (kind == 5)
        begin
            for (int k = 0; k < 9; k++)
                e[k] = elem_t'(int'($urandom_range(0, 6)) - 3);
        end
        return pack_matrix(e);
    endfunction

    task automatic report(string what, elem_t got, elem_t want);
        mismatches++;
        $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    endtask

    task automatic check_field(string what, elem_t got, elem_t want);
        if (got !== want)
            report(what, got, want);
    endtask

    always @(posedge clk)
    begin
        took = rst_n && start && !busy;
        if (took)
        begin
            pending_inverses.push_back(use_typed ? typed_exp : invert_matrix(request));
            requests_sent++;
        end
        if (rst_n && done)
        begin
            if (pending_inverses.size() == 0)
            begin
                report("unexpected result", result.b00, '0);
            end
            else
            begin
                inverse_res_t want;
                want = pending_inverses.pop_front();
                check_field("b00", result.b00, want.b00);
                check_field("b01", result.b01, want.b01);
                check_field("b02", result.b02, want.b02);
                check_field("b10", result.b10, want.b10);
                check_field("b11", result.b11, want.b11);
                check_field("b12", result.b12, want.b12);
                check_field("b20", result.b20, want.b20);
                check_field("b21", result.b21, want.b21);
                check_field("b22", result.b22, want.b22);
                check_field("det_out", result.det_out, want.det_out);
                check_field("singular", elem_t'(result.singular), elem_t'(want.singular));
                check_field("overflow", elem_t'(result.overflow), elem_t'(want.overflow));
                results_seen++;
                singular_seen += want.singular;
                overflow_seen += want.overflow;
            end
        end
    end

    task automatic send_request(matrix_req_t m, bit typed, inverse_res_t exp, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        use_typed = typed;
        typed_exp = exp;
        start <= 1'b1;
        request <= m;
        do
            @(negedge clk);
        while (!took);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_inverses.size() != 0 && guard < 10000)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    initial
    begin
        stim_row_t row;
        int        idle_pct;
        int        gap;
        elem_t     one;
        one = 32'sh0001_0000;

        row = '{diag_matrix(one, 0), 1, diag_result(one, 0, one, 0, 0)};
        directed.push_back(row);
        row = '{diag_matrix(0, 0), 1, diag_result(0, 0, 0, 1, 0)};
        directed.push_back(row);
        row = '{diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff), 1,
                diag_result(32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1, 0)};
        directed.push_back(row);
        row = '{diag_matrix(32'sh8000_0000, 32'sh8000_0000), 1,
                diag_result(32'sh8000_0000, 32'sh8000_0000, 0, 1, 0)};
        directed.push_back(row);
        row = '{diag_matrix(32'sh0002_0000, 0), 1,
                diag_result(32'sh0000_8000, 0, 32'sh0008_0000, 0, 0)};
        directed.push_back(row);
        row = '{diag_matrix(32'sh8000_0000, 0), 1,
                diag_result(32'shffff_fffe, 0, 32'sh8000_0000, 0, 1)};
        directed.push_back(row);
        row = '{diag_matrix(1, 0), 1, diag_result(32'sh7fff_ffff, 0, 0, 0, 1)};
        directed.push_back(row);
        row = '{diag_matrix(32'sh7fff_ffff, 0), 0, '0};
        directed.push_back(row);
        row = '{diag_matrix(32'shffff_0000, 32'sh7fff_ffff), 0, '0};
        directed.push_back(row);
        row = '{diag_matrix(0, one), 0, '0};
        directed.push_back(row);
        row = '{diag_matrix(32'sh8000_0000, 32'sh7fff_ffff), 0, '0};
        directed.push_back(row);
        row = '{diag_matrix(32'sh0000_0003, 32'shffff_ffff), 0, '0};
        directed.push_back(row);
        for (int k = 0; k < 8; k++)
        begin
            row = '{random_matrix(), 0, '0};
            directed.push_back(row);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[k])
            send_request(directed[k].m, directed[k].typed, directed[k].exp, 0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 77 : (phase == 3) ? 28 : 0;
            for (int n = 0; n < 260; n++)
            begin
                gap = 0;
                if (phase == 2)
                    gap = (n % 40 < 20) ? 0 : $urandom_range(0, 3);
                else
                    while ($urandom_range(0, 99) < idle_pct && gap < 20)
                        gap++;
                send_request(random_matrix(), 0, '0, gap);
            end
            drain();
        end

        repeat (60) @(negedge clk);
        $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
                 requests_sent, results_seen, singular_seen, overflow_seen);
        if (mismatches == 0 && pending_inverses.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/m3i_pkg.sv
design/m3i_cofactor.sv
design/m3i_det.sv
design/m3i_div_lane.sv
design/matrix3_inverse_top.sv
dv/tb.sv
